[src/srcomp_pkg.sv]
`default_nettype none
package srcomp_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP      = 3'd0,
    CFG_PRESS_LO  = 3'd1,
    CFG_PRESS_HI  = 3'd2,
    CFG_PRESS9_HUM = 3'd3,
    CFG_HUM       = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } raw_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [47:0] press9_hum;
    logic [39:0] hum;
  } coef_t;

  typedef enum logic [4:0] {
    S_IDLE, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_M10,
    S_DIV, S_M11, S_M12, S_M13,
    S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8, S_OUT
  } state_t;

endpackage
`default_nettype wire

[src/srcomp_queue.sv]
`default_nettype none
module srcomp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire srcomp_pkg::raw_t   push_data,
  output logic                    full,
  input  wire logic               pop,
  output logic                    empty,
  output srcomp_pkg::raw_t        head
);
  import srcomp_pkg::*;

  raw_t        slot_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

[src/srcomp_mul.sv]
`default_nettype none
module srcomp_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      p
);
  import srcomp_pkg::*;

  logic [63:0] a_r, b_r, acc_r, acc_nxt;
  logic [1:0]  ph_r;
  logic        busy_r, done_r;
  logic [31:0] op_a, op_b;
  logic [63:0] prod;

  // low 64 bits only: lo*lo + (lo*hi + hi*lo) << 32
  always_comb begin
    op_a = (ph_r == 2'd2) ? a_r[63:32] : a_r[31:0];
    op_b = (ph_r == 2'd1) ? b_r[63:32] : b_r[31:0];
    prod = op_a * op_b;
    if (ph_r == 2'd0) acc_nxt = prod;
    else              acc_nxt = acc_r + {prod[31:0], 32'd0};
  end

  assign done = done_r;
  assign p    = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 2'd0;
    end else begin
      done_r <= busy_r && (ph_r == 2'd2);
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= 2'd0;
      end else if (busy_r) begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd2) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (busy_r) acc_r <= acc_nxt;
  end

endmodule
`default_nettype wire

[src/srcomp_div.sv]
`default_nettype none
module srcomp_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      q
);
  import srcomp_pkg::*;

  logic [63:0] rem_r, dq_r, mb_r, q_r;
  logic        neg_r, busy_r, fin_r, done_r;
  logic [5:0]  cnt_r;
  logic [64:0] trial, diff;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_r, dq_r[63]};
    diff  = trial - {1'b0, mb_r};
  end

  assign done = done_r;
  assign q    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= fin_r;
      fin_r  <= busy_r && (cnt_r == 6'd63);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 64'd0;
      dq_r  <= a[63] ? (64'd0 - a) : a;
      mb_r  <= b[63] ? (64'd0 - b) : b;
      neg_r <= a[63] ^ b[63];
    end else if (busy_r) begin
      if (!diff[64]) begin
        rem_r <= diff[63:0];
        dq_r  <= {dq_r[62:0], 1'b1};
      end else begin
        rem_r <= trial[63:0];
        dq_r  <= {dq_r[62:0], 1'b0};
      end
    end
    if (fin_r) q_r <= neg_r ? (64'd0 - dq_r) : dq_r;
  end

endmodule
`default_nettype wire

[src/srcomp_core.sv]
`default_nettype none
module srcomp_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire srcomp_pkg::coef_t coef,
  input  wire logic              q_empty,
  input  wire srcomp_pkg::raw_t  q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [15:0]     out_temperature_centi,
  output logic [31:0]            out_pressure_q24_8,
  output logic                   out_pressure_valid,
  output logic [16:0]            out_humidity_q22_10
);
  import srcomp_pkg::*;

  function automatic logic [63:0] asr(input logic [63:0] x, input int n);
    logic signed [63:0] s;
    s = $signed(x) >>> n;
    return s;
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  state_t state_r, state_nxt;

  logic [19:0] rt_r, rp_r;
  logic [15:0] rh_r;
  logic [63:0] tf_r, v1_r, v2_r, sq_r, p_r, x_r, y_r;
  logic [63:0] tf_nxt, v1_nxt, v2_nxt, sq_nxt, p_nxt, x_nxt, y_nxt;
  logic        pval_r, pval_nxt, wait_r;

  logic        mul_start, mul_done, div_start, div_done, step_done, emit;
  logic [63:0] mul_a, mul_b, mp, dq;

  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] h1, h2, h3, h4, h5, h6, pv1, hv, t5, hum_c;

  logic               out_valid_r;
  logic signed [15:0] temp_out_r;
  logic [31:0]        press_out_r;
  logic               pval_out_r;
  logic [16:0]        hum_out_r;

  always_comb begin
    t1 = {48'd0, coef.temp[15:0]};
    t2 = sx16(coef.temp[31:16]);
    t3 = sx16(coef.temp[47:32]);
    p1 = {48'd0, coef.press_lo[15:0]};
    p2 = sx16(coef.press_lo[31:16]);
    p3 = sx16(coef.press_lo[47:32]);
    p4 = sx16(coef.press_lo[63:48]);
    p5 = sx16(coef.press_hi[15:0]);
    p6 = sx16(coef.press_hi[31:16]);
    p7 = sx16(coef.press_hi[47:32]);
    p8 = sx16(coef.press_hi[63:48]);
    p9 = sx16(coef.press9_hum[15:0]);
    h1 = {56'd0, coef.press9_hum[23:16]};
    h2 = sx16(coef.press9_hum[39:24]);
    h3 = {56'd0, coef.press9_hum[47:40]};
    h4 = sx16(coef.hum[15:0]);
    h5 = sx16(coef.hum[31:16]);
    h6 = {{56{coef.hum[39]}}, coef.hum[39:32]};
    pv1 = tf_r - 64'd128000;
    hv  = tf_r - 64'd76800;
  end

  srcomp_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mp)
  );

  srcomp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .a(p_r), .b(v1_r),
    .done(div_done), .q(dq)
  );

  assign emit      = !out_valid_r || out_ready;
  assign step_done = (state_r == S_DIV) ? div_done : mul_done;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!q_empty) state_nxt = S_M1;
      S_M1:   if (step_done) state_nxt = S_M2;
      S_M2:   if (step_done) state_nxt = S_M3;
      S_M3:   if (step_done) state_nxt = S_M4;
      S_M4:   if (step_done) state_nxt = S_M5;
      S_M5:   if (step_done) state_nxt = S_M6;
      S_M6:   if (step_done) state_nxt = S_M7;
      S_M7:   if (step_done) state_nxt = S_M8;
      S_M8:   if (step_done) state_nxt = S_M9;
      S_M9:   if (step_done) state_nxt = S_M10;
      S_M10:  if (step_done) state_nxt = (v1_r != 64'd0) ? S_DIV : S_H1;
      S_DIV:  if (step_done) state_nxt = S_M11;
      S_M11:  if (step_done) state_nxt = S_M12;
      S_M12:  if (step_done) state_nxt = S_M13;
      S_M13:  if (step_done) state_nxt = S_H1;
      S_H1:   if (step_done) state_nxt = S_H2;
      S_H2:   if (step_done) state_nxt = S_H3;
      S_H3:   if (step_done) state_nxt = S_H4;
      S_H4:   if (step_done) state_nxt = S_H5;
      S_H5:   if (step_done) state_nxt = S_H6;
      S_H6:   if (step_done) state_nxt = S_H7;
      S_H7:   if (step_done) state_nxt = S_H8;
      S_H8:   if (step_done) state_nxt = S_OUT;
      S_OUT:  if (emit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs: operand select and strobes
  always_comb begin
    mul_a     = 64'd0;
    mul_b     = 64'd0;
    q_pop     = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    unique case (state_r)
      S_IDLE: q_pop = !q_empty;
      S_DIV:  div_start = !wait_r;
      S_OUT:  ;
      default: mul_start = !wait_r;
    endcase
    unique case (state_r)
      S_M1: begin
        mul_a = {47'd0, rt_r[19:3]} - {47'd0, t1[15:0], 1'b0};
        mul_b = t2;
      end
      S_M2: begin
        mul_a = {48'd0, rt_r[19:4]} - t1;
        mul_b = {48'd0, rt_r[19:4]} - t1;
      end
      S_M3:  begin mul_a = sq_r; mul_b = t3; end
      S_M4:  begin mul_a = pv1;  mul_b = pv1; end
      S_M5:  begin mul_a = sq_r; mul_b = p6; end
      S_M6:  begin mul_a = pv1;  mul_b = p5; end
      S_M7:  begin mul_a = sq_r; mul_b = p3; end
      S_M8:  begin mul_a = pv1;  mul_b = p2; end
      S_M9:  begin mul_a = (64'd1 << 47) + v1_r; mul_b = p1; end
      S_M10: begin
        mul_a = ((64'd1048576 - {44'd0, rp_r}) << 31) - v2_r;
        mul_b = 64'd3125;
      end
      S_M11: begin mul_a = p9;   mul_b = asr(p_r, 13); end
      S_M12: begin mul_a = sq_r; mul_b = asr(p_r, 13); end
      S_M13: begin mul_a = p8;   mul_b = p_r; end
      S_H1:  begin mul_a = h5;   mul_b = hv; end
      S_H2:  begin mul_a = hv;   mul_b = h6; end
      S_H3:  begin mul_a = hv;   mul_b = h3; end
      S_H4:  begin mul_a = y_r;  mul_b = sq_r; end
      S_H5:  begin mul_a = y_r;  mul_b = h2; end
      S_H6:  begin mul_a = x_r;  mul_b = y_r; end
      S_H7:  begin mul_a = asr(x_r, 15); mul_b = asr(x_r, 15); end
      S_H8:  begin mul_a = sq_r; mul_b = h1; end
      default: ;
    endcase
  end

  // datapath write-back
  always_comb begin
    tf_nxt = tf_r; v1_nxt = v1_r; v2_nxt = v2_r; sq_nxt = sq_r;
    p_nxt = p_r; x_nxt = x_r; y_nxt = y_r; pval_nxt = pval_r;
    if (step_done) begin
      case (state_r)
        S_M1:  v1_nxt = asr(mp, 11);
        S_M2:  sq_nxt = asr(mp, 12);
        S_M3:  tf_nxt = v1_r + asr(mp, 14);
        S_M4:  sq_nxt = mp;
        S_M5:  v2_nxt = mp;
        S_M6:  v2_nxt = v2_r + (mp << 17) + (p4 << 35);
        S_M7:  v1_nxt = asr(mp, 8);
        S_M8:  v1_nxt = v1_r + (mp << 12);
        S_M9:  v1_nxt = asr(mp, 33);
        S_M10: begin
          p_nxt    = mp;
          pval_nxt = (v1_r != 64'd0);
        end
        S_DIV: p_nxt  = dq;
        S_M11: sq_nxt = mp;
        S_M12: v2_nxt = asr(mp, 25);
        S_M13: p_nxt  = asr(p_r + v2_r + asr(mp, 19), 8) + (p7 << 4);
        S_H1:  x_nxt  = asr({34'd0, rh_r, 14'd0} - (h4 << 20) - mp + 64'd16384, 15);
        S_H2:  y_nxt  = asr(mp, 10);
        S_H3:  sq_nxt = asr(mp, 11) + 64'd32768;
        S_H4:  y_nxt  = asr(mp, 10) + 64'd2097152;
        S_H5:  y_nxt  = asr(mp + 64'd8192, 14);
        S_H6:  x_nxt  = mp;
        S_H7:  sq_nxt = asr(mp, 7);
        S_H8:  x_nxt  = x_r - asr(mp, 4);
        default: ;
      endcase
    end
  end

  // final scaling and clamps
  always_comb begin
    t5 = asr((tf_r << 2) + tf_r + 64'd128, 8);
    if (x_r[63])                   hum_c = 64'd0;
    else if (x_r > 64'd419430400)  hum_c = 64'd419430400;
    else                           hum_c = x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (step_done)                   wait_r <= 1'b0;
      else if (mul_start || div_start) wait_r <= 1'b1;
      if (state_r == S_OUT && emit) out_valid_r <= 1'b1;
      else if (out_ready)           out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rt_r <= q_head.raw_temperature;
      rp_r <= q_head.raw_pressure;
      rh_r <= q_head.raw_humidity;
    end
    tf_r <= tf_nxt; v1_r <= v1_nxt; v2_r <= v2_nxt; sq_r <= sq_nxt;
    p_r <= p_nxt; x_r <= x_nxt; y_r <= y_nxt; pval_r <= pval_nxt;
    if (state_r == S_OUT && emit) begin
      if ($signed(t5) > 64'sd32767)       temp_out_r <= 16'sd32767;
      else if ($signed(t5) < -64'sd32768) temp_out_r <= -16'sd32768;
      else                                temp_out_r <= t5[15:0];
      press_out_r <= pval_r ? p_r[31:0] : 32'd0;
      pval_out_r  <= pval_r;
      hum_out_r   <= hum_c[28:12];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = temp_out_r;
  assign out_pressure_q24_8    = press_out_r;
  assign out_pressure_valid    = pval_out_r;
  assign out_humidity_q22_10   = hum_out_r;

endmodule
`default_nettype wire

[src/sensor_raw_compensation.sv]
`default_nettype none
// Compensates one raw temperature/pressure/humidity sample per item using the
// calibration coefficients in five configuration registers (write only while
// idle). Results: temperature in 0.01 degC (saturated), pressure in Q24.8 Pa
// with a valid flag (cleared and zero when the pressure divisor is zero), and
// humidity in Q7.10 percent clamped to 0..100. A two-item input queue lets
// samples be taken while the back end computes and a finished result waits.
// The back end finishes one item before it takes the next: it runs 21 wrapping
// 64-bit multiplies on one shared 32x32 multiplier and a radix-2 64-bit
// divide, and items whose pressure divisor is zero skip the divider and three
// multiplies. A stalled result holds the back end until it is taken.
module sensor_raw_compensation (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [19:0]                      in_raw_temperature,
  input  wire logic [19:0]                      in_raw_pressure,
  input  wire logic [15:0]                      in_raw_humidity,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [15:0]                    out_temperature_centi,
  output logic [31:0]                           out_pressure_q24_8,
  output logic                                  out_pressure_valid,
  output logic [16:0]                           out_humidity_q22_10,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [srcomp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                      cfg_data
);
  import srcomp_pkg::*;

  coef_t coef_r;
  raw_t  in_item, head;
  logic  q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_item   = '{raw_temperature: in_raw_temperature,
                       raw_pressure:    in_raw_pressure,
                       raw_humidity:    in_raw_humidity};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TEMP:       coef_r.temp       <= cfg_data[47:0];
        CFG_PRESS_LO:   coef_r.press_lo   <= cfg_data;
        CFG_PRESS_HI:   coef_r.press_hi   <= cfg_data;
        CFG_PRESS9_HUM: coef_r.press9_hum <= cfg_data[47:0];
        CFG_HUM:        coef_r.hum        <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  srcomp_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(in_valid && !q_full), .push_data(in_item), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(head)
  );

  srcomp_core u_core (
    .clk(clk), .rst_n(rst_n), .coef(coef_r),
    .q_empty(q_empty), .q_head(head), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_temperature_centi(out_temperature_centi),
    .out_pressure_q24_8(out_pressure_q24_8),
    .out_pressure_valid(out_pressure_valid),
    .out_humidity_q22_10(out_humidity_q22_10)
  );

endmodule
`default_nettype wire

[test/srcomp_checker.sv]
module srcomp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [19:0] in_raw_temperature,
  input  logic [19:0] in_raw_pressure,
  input  logic [15:0] in_raw_humidity,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_temperature_centi,
  input  logic [31:0] out_pressure_q24_8,
  input  logic        out_pressure_valid,
  input  logic [16:0] out_humidity_q22_10,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked_count,
  output int          no_press_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import srcomp_pkg::*;

  typedef struct packed {
    logic [15:0] temp_centi;
    logic [31:0] press;
    logic        press_ok;
    logic [16:0] hum;
  } reading_t;

  coef_t    coefs;
  reading_t expected_readings[$];

  function automatic logic [63:0] sx(logic [63:0] r, int lo, int bits);
    logic [63:0] v;
    v = (r >> lo) & ((64'd1 << bits) - 1);
    if (v[bits-1]) v |= ~((64'd1 << bits) - 1);
    return v;
  endfunction

  function automatic logic [63:0] ux(logic [63:0] r, int lo, int bits);
    return (r >> lo) & ((64'd1 << bits) - 1);
  endfunction

  function automatic logic [63:0] asr(logic [63:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  // signed quotient truncating toward zero, wraps on overflow
  function automatic logic [63:0] sdiv64(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q  = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic reading_t compensate_sample(logic [19:0] raw_tp, logic [19:0] raw_p,
                                                 logic [15:0] raw_h, coef_t c);
    logic [63:0] rt, rp, rh, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] h1, h2, h3, h4, h5, h6, a, b, tf, v1, v2, p, w1, w2, x, y, v;
    logic signed [63:0] s;
    reading_t r;
    rt = raw_tp; rp = raw_p; rh = raw_h;
    t1 = ux(c.temp, 0, 16);      t2 = sx(c.temp, 16, 16);     t3 = sx(c.temp, 32, 16);
    p1 = ux(c.press_lo, 0, 16);  p2 = sx(c.press_lo, 16, 16);
    p3 = sx(c.press_lo, 32, 16); p4 = sx(c.press_lo, 48, 16);
    p5 = sx(c.press_hi, 0, 16);  p6 = sx(c.press_hi, 16, 16);
    p7 = sx(c.press_hi, 32, 16); p8 = sx(c.press_hi, 48, 16);
    p9 = sx(c.press9_hum, 0, 16);  h1 = ux(c.press9_hum, 16, 8);
    h2 = sx(c.press9_hum, 24, 16); h3 = ux(c.press9_hum, 40, 8);
    h4 = sx(c.hum, 0, 16); h5 = sx(c.hum, 16, 16); h6 = sx(c.hum, 32, 8);

    a  = (rt >> 3) - (t1 << 1);
    v1 = asr(a * t2, 11);
    b  = (rt >> 4) - t1;
    v2 = asr(asr(b * b, 12) * t3, 14);
    tf = v1 + v2;
    s = asr(tf * 5 + 128, 8);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    r.temp_centi = s[15:0];

    v1 = tf - 128000;
    v2 = v1 * v1 * p6;
    v2 += (v1 * p5) << 17;
    v2 += p4 << 35;
    v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr(((64'd1 << 47) + v1) * p1, 33);
    if (v1 == 0) begin
      r.press = '0;
      r.press_ok = 1'b0;
    end else begin
      p  = 64'd1048576 - rp;
      p  = sdiv64(((p << 31) - v2) * 3125, v1);
      w1 = asr(p9 * asr(p, 13) * asr(p, 13), 25);
      w2 = asr(p8 * p, 19);
      p  = asr(p + w1 + w2, 8) + (p7 << 4);
      r.press = p[31:0];
      r.press_ok = 1'b1;
    end

    v = tf - 76800;
    x = asr((rh << 14) - (h4 << 20) - h5 * v + 16384, 15);
    y = asr(asr(v * h6, 10) * (asr(v * h3, 11) + 32768), 10) + 2097152;
    y = asr(y * h2 + 8192, 14);
    v = x * y;
    v = v - asr(asr(asr(v, 15) * asr(v, 15), 7) * h1, 4);
    s = v;
    if (s < 0) s = 0;
    if (s > 419430400) s = 419430400;
    r.hum = s[28:12];
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want, got;
    if (!rst_n) begin
      coefs = '0;
      expected_readings.delete();
      fail_count = 0;
      checked_count = 0;
      no_press_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TEMP:       coefs.temp       = cfg_data[47:0];
          CFG_PRESS_LO:   coefs.press_lo   = cfg_data;
          CFG_PRESS_HI:   coefs.press_hi   = cfg_data;
          CFG_PRESS9_HUM: coefs.press9_hum = cfg_data[47:0];
          CFG_HUM:        coefs.hum        = cfg_data[39:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_readings.push_back(compensate_sample(in_raw_temperature, in_raw_pressure,
                                                      in_raw_humidity, coefs));
      if (out_valid && out_ready) begin
        got = '{out_temperature_centi, out_pressure_q24_8, out_pressure_valid,
                out_humidity_q22_10};
        if (expected_readings.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result item %h", got);
        end else begin
          want = expected_readings.pop_front();
          checked_count++;
          if (!want.press_ok) no_press_count++;
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch item %0d: exp t=%0d p=%h pv=%b h=%0d, got t=%0d p=%h pv=%b h=%0d",
                       checked_count, $signed(want.temp_centi), want.press, want.press_ok,
                       want.hum, $signed(got.temp_centi), got.press, got.press_ok, got.hum);
          end
        end
      end
    end
    pending = expected_readings.size();
  end

endmodule

[test/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import srcomp_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [19:0] in_raw_temperature = '0;
  logic [19:0] in_raw_pressure = '0;
  logic [15:0] in_raw_humidity = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [15:0] out_temperature_centi;
  logic [31:0] out_pressure_q24_8;
  logic        out_pressure_valid;
  logic [16:0] out_humidity_q22_10;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TEMP;
  logic [63:0] cfg_data = '0;
  logic        quiet = 1'b0;
  int          fail_count, pending, checked_count, no_press_count, coef_sets;

  // plausible calibration, used as a base for most random sets
  localparam logic [47:0] TYP_TEMP = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_PLO  = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TYP_PHI  = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [47:0] TYP_P9H  = {8'd0, 16'd362, 8'd75, 16'd6000};
  localparam logic [39:0] TYP_HUM  = {8'd30, 16'd50, 16'd310};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sensor_raw_compensation DUT (.*);

  srcomp_checker u_checker (.*);

  task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_coefs(logic [63:0] t, logic [63:0] plo, logic [63:0] phi,
                            logic [63:0] p9h, logic [63:0] hum);
    // stop offering items and let the count settle before draining
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    write_reg(CFG_TEMP, t);
    write_reg(CFG_PRESS_LO, plo);
    write_reg(CFG_PRESS_HI, phi);
    write_reg(CFG_PRESS9_HUM, p9h);
    write_reg(CFG_HUM, hum);
    coef_sets++;
  endtask

  task automatic send_sample(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    in_valid <= 1'b1;
    in_raw_temperature <= rt;
    in_raw_pressure <= rp;
    in_raw_humidity <= rh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // receiver stalls in bursts
  initial begin
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    #10ms;
    $display("timeout");
    $display("FAILURE");
    $finish;
  end

  initial begin
    int n;
    logic [63:0] j;
    coef_sets = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero calibration: divisor is zero
    load_coefs('0, '0, '0, '0, '0);
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    send_sample(20'h80000, 20'h55555, 16'hAAAA);

    load_coefs(TYP_TEMP, TYP_PLO, TYP_PHI, TYP_P9H, TYP_HUM);
    send_sample(20'd519888, 20'd415148, 16'd30000);
    send_sample(20'd519888, 20'd415148, 16'd0);
    send_sample(20'd519888, 20'd415148, 16'hFFFF);
    send_sample('0, 20'd415148, 16'd30000);
    send_sample('1, 20'd415148, 16'd30000);
    send_sample(20'd519888, '0, 16'd30000);
    send_sample(20'd519888, '1, 16'd30000);
    send_sample(20'd700000, 20'd300000, 16'd45000);

    load_coefs('1, '1, '1, '1, '1);
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    send_sample(20'h12345, 20'hABCDE, 16'h5A5A);

    load_coefs({3{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {3{16'h7FFF}}, {5{8'h7F}});
    send_sample('0, '1, '0);
    send_sample('1, '0, '1);

    load_coefs({3{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {3{16'h8000}}, {5{8'h80}});
    send_sample('0, '1, '1);
    send_sample('1, '0, '0);

    n = 0;
    while (n < 900) begin
      if (n % 150 == 0) begin
        if ($urandom_range(0, 2) == 0)
          load_coefs(rand64(), rand64(), rand64(), rand64(), rand64());
        else begin
          j = rand64();
          load_coefs(TYP_TEMP ^ (j & 48'h00FF_00FF_00FF), TYP_PLO ^ (j & 64'h00FF_00FF_00FF_00FF),
                     TYP_PHI ^ (j & 64'h000F_00FF_000F_0007), TYP_P9H ^ (j & 48'h0F_00FF_0F_00FF),
                     TYP_HUM ^ (j & 40'h0F_00FF_00FF));
        end
      end
      if (n >= 800) quiet = 1'b1;
      if ($urandom_range(0, 3) == 0)
        send_sample(20'($urandom), 20'($urandom), 16'($urandom));
      else
        send_sample(20'($urandom_range(400000, 650000)), 20'($urandom_range(250000, 600000)),
                    16'($urandom_range(15000, 50000)));
      n++;
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("checked %0d results over %0d calibration sets, %0d with zero pressure divisor",
             checked_count, coef_sets, no_press_count);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
